// File: rtl/core/clw_pkg.sv
// ============================================================================
// clw_pkg: shared types and constants of the character LCD writer
// Request codes, register indexes, the init byte table and the queue entry.
// ============================================================================
package clw_pkg;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_CMD   = 2'd2;
    localparam logic [1:0] REQ_CHAR  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_CHARS_PER_LINE = 3'd0;
    localparam logic [2:0] REG_ROW0_BASE      = 3'd1;
    localparam logic [2:0] REG_ROW1_BASE      = 3'd2;
    localparam logic [2:0] REG_ROW2_BASE      = 3'd3;
    localparam logic [2:0] REG_ROW3_BASE      = 3'd4;
    localparam logic [2:0] REG_COMMAND_WAIT   = 3'd5;
    localparam logic [2:0] REG_DATA_WAIT      = 3'd6;

    localparam int MAX_ROWS = 4;

    // Controller command bytes.
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam logic [2:0] INIT_LAST_STEP = 3'd6;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [5:0]                 chars_per_line;
        logic [MAX_ROWS-1:0][6:0]   row_base;
        logic [15:0]                command_wait_us;
        logic [15:0]                data_wait_us;
    } cfg_t;

    // One byte to be sent as two strobes.
    typedef struct packed {
        logic       reg_select;
        logic [7:0] data_byte;
        logic       data_wait;   // 1: data delay, 0: command delay
        logic       last;
    } entry_t;

    typedef enum logic [2:0] {
        SEQ_INIT,
        SEQ_CLEAR,
        SEQ_CMD,
        SEQ_ADDR_CHAR,
        SEQ_CHAR
    } seq_t;

    typedef enum logic {
        FE_IDLE,
        FE_RUN
    } fe_state_t;

    typedef enum logic {
        PH_HIGH,
        PH_LOW
    } phase_t;

    // Power-up sequence of the controller in 4-bit mode.
    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        unique case (step)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h04;
            3'd5:    b = CMD_CLEAR;
            3'd6:    b = CMD_HOME;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/clw_fifo.sv
// ============================================================================
// clw_fifo: byte queue between front and back
// A small register queue that lets the front and the back stall on their own.
// ============================================================================
module clw_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  clw_pkg::entry_t  push_entry,
    input  logic             pop,
    output clw_pkg::entry_t  head_entry,
    output logic             full,
    output logic             empty
);

    clw_pkg::entry_t                       mem [clw_pkg::QUEUE_DEPTH];
    logic [clw_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [clw_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [clw_pkg::QUEUE_CNT_W-1:0]       count_reg, count_next;

    assign full       = (count_reg == clw_pkg::QUEUE_CNT_W'(clw_pkg::QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/clw_front.sv
// ============================================================================
// clw_front: request front end
// Accepts requests, tracks the message position and queues the bytes to send.
// ============================================================================
module clw_front #(
    parameter int NUM_LINES = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  clw_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [7:0]       s_byte_value,
    input  logic             s_message_start,
    output logic             q_push,
    output clw_pkg::entry_t  q_entry,
    input  logic             q_full
);

    clw_pkg::fe_state_t state_reg, state_next;
    clw_pkg::seq_t      seq_reg, seq_next;
    logic [2:0]         step_reg, step_next;
    logic [7:0]         byte_reg, byte_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         pos_reg, pos_next;

    logic       accept, load, fire, fire_last, is_char;
    logic [7:0] pos_eff;
    logic [8:0] pos9, m1, m2, m3, m4, limit, line_start;
    logic [1:0] line_idx;
    logic       beyond;

    // Line and column come from compares against multiples of the line length.
    always_comb begin
        pos_eff = (s_message_start) ? 8'd0 : pos_reg;
        pos9    = {1'b0, pos_eff};
        m1      = (cfg.chars_per_line == '0) ? 9'd1 : {3'b000, cfg.chars_per_line};
        m2      = {m1[7:0], 1'b0};
        m3      = m1 + m2;
        m4      = {m1[6:0], 2'b00};
        if (pos9 >= m3) begin
            line_idx   = 2'd3;
            line_start = m3;
        end else if (pos9 >= m2) begin
            line_idx   = 2'd2;
            line_start = m2;
        end else if (pos9 >= m1) begin
            line_idx   = 2'd1;
            line_start = m1;
        end else begin
            line_idx   = 2'd0;
            line_start = 9'd0;
        end
        case (NUM_LINES)
            1:       limit = m1;
            2:       limit = m2;
            3:       limit = m3;
            default: limit = m4;
        endcase
        beyond = (pos9 >= limit);
    end

    assign fire      = (state_reg == clw_pkg::FE_RUN) && !q_full;
    assign fire_last = fire && q_entry.last;
    assign s_ready   = (state_reg == clw_pkg::FE_IDLE) || fire_last;
    assign accept    = s_valid && s_ready;
    assign is_char   = (s_req_type == clw_pkg::REQ_CHAR);
    assign load      = accept && !(is_char && beyond);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clw_pkg::FE_IDLE: begin
                state_next = load ? clw_pkg::FE_RUN : clw_pkg::FE_IDLE;
            end
            clw_pkg::FE_RUN: begin
                if (fire_last) begin
                    state_next = load ? clw_pkg::FE_RUN : clw_pkg::FE_IDLE;
                end
            end
            default: state_next = clw_pkg::FE_IDLE;
        endcase
    end

    // Request registers and message position.
    always_comb begin
        seq_next  = seq_reg;
        byte_next = byte_reg;
        addr_next = addr_reg;
        pos_next  = pos_reg;
        step_next = fire ? step_reg + 1'b1 : step_reg;
        if (load) begin
            step_next = '0;
            byte_next = s_byte_value;
            addr_next = clw_pkg::CMD_SET_ADDR | {1'b0, cfg.row_base[line_idx]};
        end
        if (accept) begin
            unique case (s_req_type)
                clw_pkg::REQ_INIT:  seq_next = clw_pkg::SEQ_INIT;
                clw_pkg::REQ_CLEAR: seq_next = clw_pkg::SEQ_CLEAR;
                clw_pkg::REQ_CMD:   seq_next = clw_pkg::SEQ_CMD;
                default: begin
                    seq_next = (pos9 == line_start) ? clw_pkg::SEQ_ADDR_CHAR
                                                    : clw_pkg::SEQ_CHAR;
                    pos_next = beyond ? pos_eff : pos_eff + 8'd1;
                end
            endcase
        end
    end

    // Byte generation for the current step.
    always_comb begin
        q_push           = (state_reg == clw_pkg::FE_RUN) && !q_full;
        q_entry          = '0;
        unique case (seq_reg)
            clw_pkg::SEQ_INIT: begin
                q_entry.data_byte = clw_pkg::init_byte(step_reg);
                q_entry.last      = (step_reg == clw_pkg::INIT_LAST_STEP);
            end
            clw_pkg::SEQ_CLEAR: begin
                q_entry.data_byte = (step_reg == '0) ? clw_pkg::CMD_CLEAR
                                                     : clw_pkg::CMD_HOME;
                q_entry.last      = (step_reg != '0);
            end
            clw_pkg::SEQ_CMD: begin
                q_entry.data_byte = byte_reg;
                q_entry.last      = 1'b1;
            end
            clw_pkg::SEQ_ADDR_CHAR: begin
                if (step_reg == '0) begin
                    q_entry.data_byte = addr_reg;
                end else begin
                    q_entry.reg_select = 1'b1;
                    q_entry.data_byte  = byte_reg;
                    q_entry.data_wait  = 1'b1;
                    q_entry.last       = 1'b1;
                end
            end
            default: begin
                q_entry.reg_select = 1'b1;
                q_entry.data_byte  = byte_reg;
                q_entry.data_wait  = 1'b1;
                q_entry.last       = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        seq_reg  <= seq_next;
        byte_reg <= byte_next;
        addr_reg <= addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clw_pkg::FE_IDLE;
            step_reg  <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: rtl/core/clw_back.sv
// ============================================================================
// clw_back: nibble strobe back end
// Splits each queued byte into a high and a low nibble strobe with its wait.
// ============================================================================
module clw_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  clw_pkg::cfg_t    cfg,
    input  logic             q_empty,
    input  clw_pkg::entry_t  q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_reg_select,
    output logic [3:0]       m_nibble,
    output logic [15:0]      m_wait_us,
    output logic             m_last
);

    clw_pkg::phase_t  phase_reg, phase_next;
    clw_pkg::entry_t  cur_reg, cur_next;
    logic             valid_reg, valid_next;
    logic             rs_reg, rs_next;
    logic [3:0]       nibble_reg, nibble_next;
    logic [15:0]      wait_reg, wait_next;
    logic             last_reg, last_next;
    logic             out_free;

    assign out_free = !valid_reg || m_ready;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            clw_pkg::PH_HIGH: begin
                if (out_free && !q_empty) begin
                    phase_next = clw_pkg::PH_LOW;
                end
            end
            clw_pkg::PH_LOW: begin
                if (out_free) begin
                    phase_next = clw_pkg::PH_HIGH;
                end
            end
            default: phase_next = clw_pkg::PH_HIGH;
        endcase
    end

    // Output register loading.
    always_comb begin
        q_pop       = 1'b0;
        cur_next    = cur_reg;
        valid_next  = valid_reg && !m_ready;
        rs_next     = rs_reg;
        nibble_next = nibble_reg;
        wait_next   = wait_reg;
        last_next   = last_reg;
        if (out_free) begin
            unique case (phase_reg)
                clw_pkg::PH_HIGH: begin
                    if (!q_empty) begin
                        q_pop       = 1'b1;
                        cur_next    = q_head;
                        valid_next  = 1'b1;
                        rs_next     = q_head.reg_select;
                        nibble_next = q_head.data_byte[7:4];
                        wait_next   = '0;
                        last_next   = 1'b0;
                    end
                end
                default: begin
                    valid_next  = 1'b1;
                    rs_next     = cur_reg.reg_select;
                    nibble_next = cur_reg.data_byte[3:0];
                    wait_next   = cur_reg.data_wait ? cfg.data_wait_us
                                                    : cfg.command_wait_us;
                    last_next   = cur_reg.last;
                end
            endcase
        end
    end

    assign m_valid      = valid_reg;
    assign m_reg_select = rs_reg;
    assign m_nibble     = nibble_reg;
    assign m_wait_us    = wait_reg;
    assign m_last       = last_reg;

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        rs_reg     <= rs_next;
        nibble_reg <= nibble_next;
        wait_reg   <= wait_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= clw_pkg::PH_HIGH;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: rtl/core/char_lcd_4bit_writer.sv
// ============================================================================
// char_lcd_4bit_writer: character LCD writer for a 4-bit controller bus
// Turns init, clear, raw command and message character items into strobes.
// ============================================================================
// Usage:
// The s_ channel takes one item per request: an init sequence, a clear and
// home, a raw command byte or one message character. The m_ channel gives
// one item per bus strobe: register select, the four data lines and the
// wait in microseconds that must follow the strobe, with m_last on the
// final strobe of a request. Each byte is sent high nibble first.
// The first strobe of a request passes the front's request registers, the
// byte queue and the output register. The output register gives one strobe
// per cycle while m_ready is high. A character takes two or four strobes (four
// when it opens a line and needs a set-address command), a raw command two
// and init 14. The front accepts the next item on the cycle its last byte is
// queued, so requests follow each other without gaps in the strobe stream.
// Reset clears the message position to zero and loads the default line
// length, row addresses and delays. When the receiver holds m_ready low,
// the strobe holds, the byte queue fills and then s_ready drops.
// The user must write the configuration registers through cfg_wr_en only while idle; the block does not enforce it.
// ============================================================================
module char_lcd_4bit_writer #(
    parameter int NUM_LINES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_byte_value,
    input  logic        s_message_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic [3:0]  m_nibble,
    output logic [15:0] m_wait_us,
    output logic        m_last
);

    // Configuration registers. All of them are control-like settings, so
    // they are set to their defaults by reset.
    clw_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                clw_pkg::REG_CHARS_PER_LINE: cfg_next.chars_per_line  = cfg_wdata[5:0];
                clw_pkg::REG_ROW0_BASE:      cfg_next.row_base[0]     = cfg_wdata[6:0];
                clw_pkg::REG_ROW1_BASE:      cfg_next.row_base[1]     = cfg_wdata[6:0];
                clw_pkg::REG_ROW2_BASE:      cfg_next.row_base[2]     = cfg_wdata[6:0];
                clw_pkg::REG_ROW3_BASE:      cfg_next.row_base[3]     = cfg_wdata[6:0];
                clw_pkg::REG_COMMAND_WAIT:   cfg_next.command_wait_us = cfg_wdata;
                clw_pkg::REG_DATA_WAIT:      cfg_next.data_wait_us    = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chars_per_line  <= 6'd20;
            cfg_reg.row_base[0]     <= 7'h00;
            cfg_reg.row_base[1]     <= 7'h40;
            cfg_reg.row_base[2]     <= 7'h14;
            cfg_reg.row_base[3]     <= 7'h54;
            cfg_reg.command_wait_us <= 16'd2000;
            cfg_reg.data_wait_us    <= 16'd37;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classifies each item and queues one byte per cycle while the queue is not full.
    logic            q_push, q_pop, q_full, q_empty;
    clw_pkg::entry_t q_push_entry, q_head;

    clw_front #(
        .NUM_LINES (NUM_LINES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_byte_value    (s_byte_value),
        .s_message_start (s_message_start),
        .q_push          (q_push),
        .q_entry         (q_push_entry),
        .q_full          (q_full)
    );

    // The queue decouples byte generation from strobe output.
    clw_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_entry (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Back end: two strobes per byte from a registered output stage.
    clw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_nibble     (m_nibble),
        .m_wait_us    (m_wait_us),
        .m_last       (m_last)
    );

`ifndef ASSERT_OFF
    // The back end never takes a byte from an empty queue.
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("byte taken from empty queue");

    // A queued byte reaches an idle output register on the next cycle.
    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_empty && !m_valid) |=> m_valid)
        else $error("queued byte did not reach idle output");

    // Reset leaves no strobe pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("strobe valid after reset");
`endif

endmodule
